/* hdl/msp_pkg.sv */
// ----------------------------------------------------------------------------
// msp_pkg
// Shared types and constants of the motor speed and position PID controller.
// ----------------------------------------------------------------------------
package msp_pkg;

    localparam int MulW = 64;   // accumulator width of the serial multiplier
    localparam int MplW = 20;   // multiplier operand width (largest constant is 1e6)
    localparam int DenW = 34;   // elapsed_ms * 256000
    localparam int QW   = 16;   // quotient bits produced by the divider

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_LOOP_MODE   = 3'd0,
        REG_GAIN_P      = 3'd1,
        REG_GAIN_I      = 3'd2,
        REG_GAIN_D      = 3'd3,
        REG_DRIVE_LIMIT = 3'd4,
        REG_SPEED_GOAL  = 3'd5,
        REG_ANGLE_GOAL  = 3'd6
    } cfg_reg_t;

    localparam logic signed [17:0] OVERSHOOT_RPM = 18'sd500;
    localparam logic signed [15:0] BRAKE_CURRENT = 16'sd300;
    localparam logic signed [13:0] HALF_TURN     = 14'sd1800;
    localparam logic signed [13:0] FULL_TURN     = 14'sd3600;
    localparam logic [11:0]        FULL_TURN_U   = 12'd3600;
    localparam logic signed [16:0] REACH_WINDOW  = 17'sd50;
    localparam logic [15:0]        DEFAULT_MS    = 16'd10;
    localparam logic [MplW-1:0]    SCALE_P       = 20'd1000;
    localparam logic [MplW-1:0]    SCALE_D       = 20'd1000000;
    localparam logic [MplW-1:0]    SCALE_DEN     = 20'd256000;

    typedef enum logic [3:0] {
        ST_IDLE, ST_ERR, ST_DEN, ST_I1, ST_I2, ST_ICLP, ST_P1, ST_P2,
        ST_P3, ST_D1, ST_D2, ST_DST, ST_DIV, ST_FIN
    } pid_state_t;

    typedef struct packed {
        logic                   start;
        logic signed [MulW-1:0] mcand;
        logic [MplW-1:0]        mplier;
    } mul_req_t;

    typedef struct packed {
        logic                   start;
        logic signed [MulW-1:0] num;
        logic [DenW-1:0]        den;
        logic [14:0]            limit;
    } div_req_t;

endpackage

/* hdl/motor_speed_position_pid.sv */
// ----------------------------------------------------------------------------
// motor_speed_position_pid
// Speed or position PID step with overshoot braking and a clamped integral.
// ----------------------------------------------------------------------------
// A braking request goes from the error step straight to the result; otherwise
// the serial multiplier runs once per multiplier (ms twice, gain_i, gain_p,
// gain_d and the three scale constants) before the divider forms the result.
// Throughput: one request at a time; the next is taken once the result is stored.
// Reset (aresetn, synchronous, active low) clears the PID state, the reached
// flag and the output valid, and loads the register defaults (limit 16384).
module motor_speed_position_pid import msp_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wen,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_measured_speed,
    input  logic [8:0]         s_measured_angle,
    input  logic [15:0]        s_elapsed_ms,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_drive_current,
    output logic signed [16:0] m_loop_error,
    output logic               m_braking,
    output logic               m_target_reached
);

    // Configuration registers.
    logic               mode_reg;
    logic [15:0]        gain_p_reg, gain_i_reg, gain_d_reg;
    logic [14:0]        limit_reg;
    logic signed [15:0] speed_goal_reg;
    logic [11:0]        angle_goal_reg;

    pid_state_t state_reg, state_next;

    // Captured request and working values.
    logic signed [15:0] speed_reg;
    logic [8:0]         angle_reg;
    logic [15:0]        ms_reg;
    logic signed [16:0] e_reg;
    logic               brake_reg;
    logic               win_reg;
    logic signed [15:0] drive_reg;
    logic               reached_reg;
    logic signed [47:0] integral_reg;
    logic signed [16:0] last_err_reg;
    logic signed [51:0] sum_reg;
    logic [DenW-1:0]    den_reg;
    logic signed [MulW-1:0] x_reg;
    logic signed [MulW-1:0] num_reg;

    // Result register, which frees the datapath while a result waits.
    logic               m_valid_reg;
    logic signed [15:0] out_drive_reg;
    logic signed [16:0] out_err_reg;
    logic               out_brake_reg;
    logic               out_reach_reg;

    mul_req_t               mul_req;
    logic                   mul_done;
    logic signed [MulW-1:0] mul_prod;
    div_req_t               div_req;
    logic                   div_done;
    logic signed [QW-1:0]   div_result;

    logic               out_free;
    logic               accept;

    // Error computation for both loops.
    logic signed [16:0] spd_err;
    logic signed [17:0] speed_x, goal_x;
    logic               over_pos, over_neg, brake_now;
    logic [12:0]        ang10;
    logic signed [13:0] pos_raw, pos_wrap;
    logic signed [16:0] pos_err, e_sel;
    logic               win_now;
    logic signed [17:0] de;
    logic [21:0]        lim125;
    logic [33:0]        lim_i;
    logic signed [51:0] lim_pos, lim_neg;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign speed_x   = {{2{speed_reg[15]}}, speed_reg};
    assign goal_x    = {{2{speed_goal_reg[15]}}, speed_goal_reg};
    assign spd_err   = 17'(goal_x - speed_x);
    assign over_pos  = !speed_goal_reg[15] && (speed_x > goal_x + OVERSHOOT_RPM);
    assign over_neg  = speed_goal_reg[15] && (speed_x < goal_x - OVERSHOOT_RPM);
    assign brake_now = !mode_reg && (over_pos || over_neg);

    // Angle times ten, error in tenths of a degree, wrapped once to +-180.
    assign ang10   = {1'b0, angle_reg, 3'b000} + {3'b000, angle_reg, 1'b0};
    assign pos_raw = $signed({2'b00, angle_goal_reg}) - $signed({1'b0, ang10});
    always_comb begin
        if (pos_raw > HALF_TURN) begin
            pos_wrap = pos_raw - FULL_TURN;
        end else if (pos_raw < -HALF_TURN) begin
            pos_wrap = pos_raw + FULL_TURN;
        end else begin
            pos_wrap = pos_raw;
        end
    end
    assign pos_err = {{3{pos_wrap[13]}}, pos_wrap};
    assign e_sel   = mode_reg ? pos_err : spd_err;
    assign win_now = mode_reg && (pos_err < REACH_WINDOW) && (pos_err > -REACH_WINDOW);

    assign de = {e_reg[16], e_reg} - {last_err_reg[16], last_err_reg};

    // Integral limit is 2 * limit * 256000 = (limit * 125) << 12.
    assign lim125  = (22'(limit_reg) << 7) - (22'(limit_reg) << 1) - 22'(limit_reg);
    assign lim_i   = {lim125, 12'b0};
    assign lim_pos = $signed({18'b0, lim_i});
    assign lim_neg = -lim_pos;

    // Next-state logic of the step sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_valid) state_next = ST_ERR;
            ST_ERR:  state_next = brake_now ? ST_FIN : ST_DEN;
            ST_DEN:  if (mul_done) state_next = ST_I1;
            ST_I1:   if (mul_done) state_next = ST_I2;
            ST_I2:   if (mul_done) state_next = ST_ICLP;
            ST_ICLP: state_next = ST_P1;
            ST_P1:   if (mul_done) state_next = ST_P2;
            ST_P2:   if (mul_done) state_next = ST_P3;
            ST_P3:   if (mul_done) state_next = ST_D1;
            ST_D1:   if (mul_done) state_next = ST_D2;
            ST_D2:   if (mul_done) state_next = ST_DST;
            ST_DST:  state_next = ST_DIV;
            ST_DIV:  if (div_done) state_next = ST_FIN;
            ST_FIN:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: each multiply is launched on entry to its state,
    // taking the previous product straight from the multiplier where chained.
    always_comb begin
        mul_req.start  = 1'b0;
        mul_req.mcand  = '0;
        mul_req.mplier = '0;
        unique case (state_next)
            ST_DEN: begin
                mul_req.mcand  = {{(MulW-16){1'b0}}, ms_reg};
                mul_req.mplier = SCALE_DEN;
            end
            ST_I1: begin
                mul_req.mcand  = {{(MulW-17){e_reg[16]}}, e_reg};
                mul_req.mplier = {4'b0, gain_i_reg};
            end
            ST_I2: begin
                mul_req.mcand  = mul_prod;
                mul_req.mplier = {4'b0, ms_reg};
            end
            ST_P1: begin
                mul_req.mcand  = {{(MulW-17){e_reg[16]}}, e_reg};
                mul_req.mplier = {4'b0, gain_p_reg};
            end
            ST_P2: begin
                mul_req.mcand  = mul_prod;
                mul_req.mplier = SCALE_P;
            end
            ST_P3: begin
                mul_req.mcand  = mul_prod + {{(MulW-48){integral_reg[47]}}, integral_reg};
                mul_req.mplier = {4'b0, ms_reg};
            end
            ST_D1: begin
                mul_req.mcand  = {{(MulW-18){de[17]}}, de};
                mul_req.mplier = {4'b0, gain_d_reg};
            end
            ST_D2: begin
                mul_req.mcand  = mul_prod;
                mul_req.mplier = SCALE_D;
            end
            default: begin
                mul_req.mcand  = '0;
                mul_req.mplier = '0;
            end
        endcase
        if (state_next == state_reg) begin
            mul_req.start = 1'b0;
        end else if (state_next == ST_DEN || state_next == ST_I1 || state_next == ST_I2 ||
                     state_next == ST_P1 || state_next == ST_P2 || state_next == ST_P3 ||
                     state_next == ST_D1 || state_next == ST_D2) begin
            mul_req.start = 1'b1;
        end
        div_req.start = (state_reg == ST_DST);
        div_req.num   = num_reg;
        div_req.den   = den_reg;
        div_req.limit = limit_reg;
    end

    msp_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .done    (mul_done),
        .product (mul_prod)
    );

    msp_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .done    (div_done),
        .result  (div_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            mode_reg       <= 1'b0;
            gain_p_reg     <= '0;
            gain_i_reg     <= '0;
            gain_d_reg     <= '0;
            limit_reg      <= 15'd16384;
            speed_goal_reg <= '0;
            angle_goal_reg <= '0;
            integral_reg   <= '0;
            last_err_reg   <= '0;
            reached_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            // A new result may replace one that leaves in the same cycle.
            if (state_reg == ST_FIN && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_ERR: begin
                    e_reg     <= e_sel;
                    brake_reg <= brake_now;
                    win_reg   <= win_now;
                    if (brake_now) begin
                        drive_reg   <= over_pos ? -BRAKE_CURRENT : BRAKE_CURRENT;
                        reached_reg <= 1'b0;
                    end
                end
                ST_ICLP: begin
                    if (sum_reg > lim_pos) begin
                        integral_reg <= lim_pos[47:0];
                    end else if (sum_reg < lim_neg) begin
                        integral_reg <= lim_neg[47:0];
                    end else begin
                        integral_reg <= sum_reg[47:0];
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        drive_reg    <= win_reg ? 16'sd0 : div_result;
                        last_err_reg <= e_reg;
                        if (win_reg) begin
                            reached_reg <= 1'b1;
                        end
                    end
                end
                default: ;
            endcase
            // The user must write the registers only while the block is idle; the block itself does not enforce it.
            if (cfg_wen) begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_LOOP_MODE:   mode_reg   <= cfg_wdata[0];
                    REG_GAIN_P:      gain_p_reg <= cfg_wdata;
                    REG_GAIN_I:      gain_i_reg <= cfg_wdata;
                    REG_GAIN_D:      gain_d_reg <= cfg_wdata;
                    REG_DRIVE_LIMIT: limit_reg  <= cfg_wdata[14:0];
                    REG_SPEED_GOAL: begin
                        speed_goal_reg <= cfg_wdata;
                        reached_reg    <= 1'b0;
                    end
                    REG_ANGLE_GOAL: begin
                        angle_goal_reg <= (cfg_wdata[11:0] >= FULL_TURN_U) ?
                                          cfg_wdata[11:0] - FULL_TURN_U : cfg_wdata[11:0];
                        reached_reg    <= 1'b0;
                    end
                    default: ;
                endcase
            end
        end
        // Payload registers.
        if (accept) begin
            speed_reg <= s_measured_speed;
            angle_reg <= s_measured_angle;
            ms_reg    <= (s_elapsed_ms == 16'd0) ? DEFAULT_MS : s_elapsed_ms;
        end
        if (state_reg == ST_DEN && mul_done) begin
            den_reg <= mul_prod[DenW-1:0];
        end
        if (state_reg == ST_I2 && mul_done) begin
            sum_reg <= 52'(mul_prod + {{(MulW-48){integral_reg[47]}}, integral_reg});
        end
        if (state_reg == ST_P3 && mul_done) begin
            x_reg <= mul_prod;
        end
        if (state_reg == ST_D2 && mul_done) begin
            num_reg <= x_reg + mul_prod;
        end
        if (state_reg == ST_FIN && out_free) begin
            out_drive_reg <= drive_reg;
            out_err_reg   <= e_reg;
            out_brake_reg <= brake_reg;
            out_reach_reg <= reached_reg;
        end
    end

    assign s_ready          = (state_reg == ST_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_drive_current  = out_drive_reg;
    assign m_loop_error     = out_err_reg;
    assign m_braking        = out_brake_reg;
    assign m_target_reached = out_reach_reg;

    // An accepted request always starts with the error computation.
    a_accept_to_err: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == ST_ERR)
        else $error("accepted request did not enter error step");

    // A braking result carries the fixed current and never reports reached.
    a_brake_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_braking) |->
        ((m_drive_current == BRAKE_CURRENT || m_drive_current == -BRAKE_CURRENT)
         && !m_target_reached))
        else $error("braking result inconsistent");

    // The divider output stays inside the drive limit.
    a_div_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && div_done) |->
        (div_result <= $signed({1'b0, limit_reg}) && div_result >= -$signed({1'b0, limit_reg})))
        else $error("quotient outside drive limit");

    // The stored integral never leaves its clamp range.
    a_int_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(state_reg == ST_ICLP) |->
        ($signed({{4{integral_reg[47]}}, integral_reg}) <= lim_pos &&
         $signed({{4{integral_reg[47]}}, integral_reg}) >= lim_neg))
        else $error("integral outside clamp range");

endmodule

/* hdl/msp_mul.sv */
// ----------------------------------------------------------------------------
// msp_mul
// Bit-serial shift-and-add multiplier: signed multiplicand, unsigned multiplier.
// ----------------------------------------------------------------------------
module msp_mul import msp_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  mul_req_t               req,
    output logic                   done,
    output logic signed [MulW-1:0] product
);

    logic signed [MulW-1:0] acc_reg, acc_next;
    logic signed [MulW-1:0] mc_reg, mc_next;
    logic [MplW-1:0]        mp_reg, mp_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;

    // One multiplier bit per cycle; finishes once no set bits remain.
    always_comb begin
        acc_next  = acc_reg;
        mc_next   = mc_reg;
        mp_next   = mp_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            acc_next  = '0;
            mc_next   = req.mcand;
            mp_next   = req.mplier;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (mp_reg[0]) begin
                acc_next = acc_reg + mc_reg;
            end
            mc_next = mc_reg <<< 1;
            mp_next = mp_reg >> 1;
            if (mp_reg[MplW-1:1] == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        acc_reg <= acc_next;
        mc_reg  <= mc_next;
        mp_reg  <= mp_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

/* hdl/msp_div.sv */
// ----------------------------------------------------------------------------
// msp_div
// Restoring divider, one quotient bit per cycle, truncating toward zero and
// clamping the quotient to the drive limit.
// ----------------------------------------------------------------------------
module msp_div import msp_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  div_req_t               req,
    output logic                   done,
    output logic signed [QW-1:0]   result
);

    localparam int DvsW = DenW + QW;

    logic [MulW-1:0]      rem_reg, rem_next;
    logic [DvsW-1:0]      dvs_reg, dvs_next;
    logic [4:0]           cnt_reg, cnt_next;
    logic [QW-1:0]        q_reg, q_next;
    logic                 sat_reg, sat_next;
    logic                 neg_reg, neg_next;
    logic [14:0]          lim_reg, lim_next;
    logic                 busy_reg, busy_next;
    logic                 fin_reg, fin_next;
    logic                 done_reg, done_next;
    logic signed [QW-1:0] res_reg, res_next;
    logic                 ge;
    logic [QW-1:0]        mag;

    assign ge = rem_reg >= {{(MulW-DvsW){1'b0}}, dvs_reg};

    always_comb begin
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        sat_next  = sat_reg;
        neg_next  = neg_reg;
        lim_next  = lim_reg;
        busy_next = busy_reg;
        fin_next  = 1'b0;
        done_next = 1'b0;
        res_next  = res_reg;
        mag       = (sat_reg || (q_reg > {1'b0, lim_reg})) ? {1'b0, lim_reg} : q_reg;
        if (req.start) begin
            rem_next  = req.num[MulW-1] ? MulW'(-req.num) : MulW'(req.num);
            dvs_next  = {req.den, {QW{1'b0}}};
            cnt_next  = 5'(QW);
            q_next    = '0;
            sat_next  = 1'b0;
            neg_next  = req.num[MulW-1];
            lim_next  = req.limit;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // The first step only tests whether the quotient overflows.
            if (cnt_reg == 5'(QW)) begin
                sat_next = ge;
            end else begin
                q_next = {q_reg[QW-2:0], ge};
                if (ge) begin
                    rem_next = rem_reg - {{(MulW-DvsW){1'b0}}, dvs_reg};
                end
            end
            dvs_next = dvs_reg >> 1;
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0) begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end else if (fin_reg) begin
            res_next  = neg_reg ? -$signed(mag) : $signed(mag);
            done_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        cnt_reg <= cnt_next;
        q_reg   <= q_next;
        sat_reg <= sat_next;
        neg_reg <= neg_next;
        lim_reg <= lim_next;
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule
